/* src/lsd_pkg.sv */
// Package with the shared types and constants of the stego stream decoder.
package lsd_pkg;

  localparam int unsigned MAX_EXT_LEN = 9;

  localparam int unsigned HDR_W = 10;
  localparam int unsigned MAGIC_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned EXT_W = 4;
  localparam int unsigned VALUE_W = 32;

  localparam logic [HDR_W-1:0] HEADER_SKIP_RESET = 10'd54;
  localparam logic [MAGIC_W-1:0] MAGIC_WORD_RESET = 16'd9002;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SKIP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = 1'd1;

  typedef enum logic [2:0] {
    K_SIZE   = 3'd0,
    K_EXTLEN = 3'd1,
    K_EXTB   = 3'd2,
    K_DATA   = 3'd3,
    K_MAGIC  = 3'd4,
    K_EXTERR = 3'd5
  } kind_t;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_HEADER = 7'b0000010,
    PH_MAGIC  = 7'b0000100,
    PH_SIZE   = 7'b0001000,
    PH_EXTLEN = 7'b0010000,
    PH_EXT    = 7'b0100000,
    PH_DATA   = 7'b1000000
  } phase_t;

endpackage

/* src/lsd_if.sv */
// Stream interfaces for image bytes in and decoded results out.
interface lsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cover_byte;
  logic       first;

  modport source (output valid, output cover_byte, output first, input ready);
  modport sink (input valid, input cover_byte, input first, output ready);
endinterface

interface lsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic        last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink (input valid, input kind, input value, input last, output ready);
endinterface

/* src/lsb_stego_stream_decoder.sv */
// Top level of the LSB steganography stream decoder.
//
//   Channel   Direction  Contents
//   in_ch     sink       cover_byte, first
//   out_ch    source     kind, value, last
//   cfg_*     write      cfg_we, cfg_index, cfg_data (header_skip, magic_word)
//
// The parser state updates on each accepted image byte.
// A result lands in a single output register in the cycle after its byte is taken.
// A new byte is taken whenever the output register is empty or is being emptied.
// Reset returns the parser to idle and loads the register defaults.
module lsb_stego_stream_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  lsd_in_if.sink                       in_ch,
  lsd_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [lsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsd_pkg::*;

  logic [HDR_W-1:0]   header_skip_r;
  logic [MAGIC_W-1:0] magic_word_r;

  phase_t             phase_r, phase_nxt;
  logic [HDR_W-1:0]   pos_r, pos_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic [31:0]        data_r, data_nxt;
  logic [EXT_W-1:0]   ext_r, ext_nxt;
  logic               mi_r, mi_nxt;

  logic               out_valid_r;
  kind_t              out_kind_r, kind_nxt;
  logic [31:0]        out_value_r, value_nxt;
  logic               out_last_r, last_nxt;
  logic               emit_nxt;

  logic               accept;
  logic               done;
  logic [31:0]        word;
  logic [7:0]         byte_val;
  logic [7:0]         want;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.value = out_value_r;
  assign out_ch.last  = out_last_r;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    data_nxt  = data_r;
    ext_nxt   = ext_r;
    mi_nxt    = mi_r;
    emit_nxt  = 1'b0;
    kind_nxt  = K_SIZE;
    value_nxt = '0;
    last_nxt  = 1'b0;
    done      = 1'b0;
    word      = '0;
    byte_val  = '0;
    want      = '0;

    if (in_ch.first) begin
      phase_nxt = PH_HEADER;
      pos_nxt   = '0;
      acc_nxt   = '0;
      data_nxt  = '0;
      ext_nxt   = '0;
      mi_nxt    = 1'b0;
    end

    if (phase_nxt == PH_IDLE) begin
      done = 1'b1;
    end else if (phase_nxt == PH_HEADER) begin
      if (pos_nxt < header_skip_r) begin
        pos_nxt = pos_nxt + HDR_W'(1);
        done    = 1'b1;
      end else begin
        phase_nxt = PH_MAGIC;
        pos_nxt   = '0;
        acc_nxt   = '0;
      end
    end

    if (!done) begin
      acc_nxt = {acc_nxt[30:0], in_ch.cover_byte[0]};
      pos_nxt = pos_nxt + HDR_W'(1);

      if (phase_nxt == PH_SIZE || phase_nxt == PH_EXTLEN) begin
        if (pos_nxt >= 10'd32) begin
          word    = acc_nxt;
          pos_nxt = '0;
          acc_nxt = '0;
          emit_nxt  = 1'b1;
          value_nxt = word;
          if (phase_nxt == PH_SIZE) begin
            data_nxt  = word[31] ? 32'd0 : word;
            phase_nxt = PH_EXTLEN;
            kind_nxt  = K_SIZE;
          end else if (!word[31] && word > 32'(MAX_EXT_LEN)) begin
            phase_nxt = PH_IDLE;
            kind_nxt  = K_EXTERR;
            last_nxt  = 1'b1;
          end else begin
            ext_nxt  = word[31] ? '0 : word[EXT_W-1:0];
            kind_nxt = K_EXTLEN;
            if (ext_nxt != '0) begin
              phase_nxt = PH_EXT;
            end else if (data_nxt != 32'd0) begin
              phase_nxt = PH_DATA;
            end else begin
              phase_nxt = PH_IDLE;
              last_nxt  = 1'b1;
            end
          end
        end
      end else if (pos_nxt >= 10'd8) begin
        byte_val = acc_nxt[7:0];
        pos_nxt  = '0;
        acc_nxt  = '0;
        case (phase_nxt)
          PH_MAGIC: begin
            want = mi_nxt ? magic_word_r[7:0] : magic_word_r[15:8];
            if (byte_val != want) begin
              phase_nxt = PH_IDLE;
              mi_nxt    = 1'b0;
              emit_nxt  = 1'b1;
              kind_nxt  = K_MAGIC;
              value_nxt = {24'd0, byte_val};
              last_nxt  = 1'b1;
            end else if (mi_nxt) begin
              mi_nxt    = 1'b0;
              phase_nxt = PH_SIZE;
            end else begin
              mi_nxt = 1'b1;
            end
          end
          PH_EXT: begin
            ext_nxt   = ext_nxt - EXT_W'(1);
            emit_nxt  = 1'b1;
            kind_nxt  = K_EXTB;
            value_nxt = {24'd0, byte_val};
            if (ext_nxt == '0) begin
              if (data_nxt != 32'd0) begin
                phase_nxt = PH_DATA;
              end else begin
                phase_nxt = PH_IDLE;
                last_nxt  = 1'b1;
              end
            end
          end
          PH_DATA: begin
            data_nxt  = data_nxt - 32'd1;
            emit_nxt  = 1'b1;
            kind_nxt  = K_DATA;
            value_nxt = {24'd0, byte_val};
            if (data_nxt == 32'd0) begin
              phase_nxt = PH_IDLE;
              last_nxt  = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_skip_r <= HEADER_SKIP_RESET;
      magic_word_r  <= MAGIC_WORD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_SKIP: header_skip_r <= cfg_data[HDR_W-1:0];
        CFG_MAGIC_WORD:  magic_word_r  <= cfg_data[MAGIC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      acc_r       <= '0;
      data_r      <= '0;
      ext_r       <= '0;
      mi_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        acc_r   <= acc_nxt;
        data_r  <= data_nxt;
        ext_r   <= ext_nxt;
        mi_r    <= mi_nxt;
      end
      if (accept && emit_nxt) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit_nxt) begin
      out_kind_r  <= kind_nxt;
      out_value_r <= value_nxt;
      out_last_r  <= last_nxt;
    end
  end

endmodule

/* dv/lsd_result_checker.sv */
// Checker that predicts the stego decoder's results from observed transfers and compares them.
module lsd_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  lsd_in_if                              in_mon,
  lsd_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [lsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending,
  output int                             results_seen
);
  import lsd_pkg::*;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } result_t;

  result_t expected_results[$];

  logic [HDR_W-1:0]   skip_reg;
  logic [MAGIC_W-1:0] magic_reg;

  phase_t             parse_phase;
  logic [HDR_W-1:0]   position;
  logic [31:0]        shreg;
  logic [31:0]        data_left;
  logic [EXT_W-1:0]   ext_left;
  logic               magic_second;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%08h, expected 0x%08h (result %0d)",
             what, got, want, results_seen);
    mismatches++;
  endtask

  function automatic void add_expected(kind_t k, logic [31:0] v, logic l);
    expected_results.push_back('{kind: k, value: v, last: l});
  endfunction

  task automatic decode_byte(input logic [7:0] img, input logic restart);
    logic [31:0] word;
    logic [7:0]  want;
    if (restart) begin
      parse_phase = PH_HEADER;
      position = '0;
      shreg = '0;
      data_left = '0;
      ext_left = '0;
      magic_second = 1'b0;
    end
    if (parse_phase == PH_IDLE) return;
    if (parse_phase == PH_HEADER) begin
      if (position < skip_reg) begin
        position = position + 1'b1;
        return;
      end
      parse_phase = PH_MAGIC;
      position = '0;
      shreg = '0;
    end
    shreg = {shreg[30:0], img[0]};
    position = position + 1'b1;
    if (parse_phase == PH_SIZE || parse_phase == PH_EXTLEN) begin
      if (position < 32) return;
      word = shreg;
      position = '0;
      shreg = '0;
      if (parse_phase == PH_SIZE) begin
        data_left = word[31] ? '0 : word;
        parse_phase = PH_EXTLEN;
        add_expected(K_SIZE, word, 1'b0);
      end else if (!word[31] && word > MAX_EXT_LEN) begin
        parse_phase = PH_IDLE;
        add_expected(K_EXTERR, word, 1'b1);
      end else begin
        ext_left = word[31] ? '0 : word[EXT_W-1:0];
        if (ext_left != 0) parse_phase = PH_EXT;
        else if (data_left != 0) parse_phase = PH_DATA;
        else parse_phase = PH_IDLE;
        add_expected(K_EXTLEN, word, parse_phase == PH_IDLE);
      end
      return;
    end
    if (position < 8) return;
    word = {24'd0, shreg[7:0]};
    position = '0;
    shreg = '0;
    case (parse_phase)
      PH_MAGIC: begin
        want = magic_second ? magic_reg[7:0] : magic_reg[15:8];
        if (word[7:0] != want) begin
          parse_phase = PH_IDLE;
          magic_second = 1'b0;
          add_expected(K_MAGIC, word, 1'b1);
        end else if (magic_second) begin
          magic_second = 1'b0;
          parse_phase = PH_SIZE;
        end else begin
          magic_second = 1'b1;
        end
      end
      PH_EXT: begin
        ext_left = ext_left - 1'b1;
        if (ext_left == 0) parse_phase = (data_left != 0) ? PH_DATA : PH_IDLE;
        add_expected(K_EXTB, word, parse_phase == PH_IDLE);
      end
      default: begin
        data_left = data_left - 1;
        if (data_left == 0) parse_phase = PH_IDLE;
        add_expected(K_DATA, word, parse_phase == PH_IDLE);
      end
    endcase
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected", out_mon.value, '0);
      return;
    end
    want = expected_results.pop_front();
    if (out_mon.kind !== want.kind)
      report_mismatch("kind", 32'(out_mon.kind), 32'(want.kind));
    if (out_mon.value !== want.value) report_mismatch("value", out_mon.value, want.value);
    if (out_mon.last !== want.last)
      report_mismatch("last", 32'(out_mon.last), 32'(want.last));
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      skip_reg = HEADER_SKIP_RESET;
      magic_reg = MAGIC_WORD_RESET;
      parse_phase = PH_IDLE;
      position = '0;
      shreg = '0;
      data_left = '0;
      ext_left = '0;
      magic_second = 1'b0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEADER_SKIP: skip_reg = cfg_data[HDR_W-1:0];
          CFG_MAGIC_WORD: magic_reg = cfg_data[MAGIC_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) decode_byte(in_mon.cover_byte, in_mon.first);
    end
    pending <= expected_results.size();
  end

endmodule

/* dv/lsb_stego_stream_decoder_test.sv */
// Top of the stego decoder testbench: clock, reset, image stimulus, result sink and verdict.
module lsb_stego_stream_decoder_test;
  import lsd_pkg::*;

  localparam int RANDOM_BYTES       = 250;
  localparam int HOLD_CYCLES        = 400;
  localparam int QUIET_LIMIT        = 4000;
  localparam int DRAIN_CYCLES       = 4;
  localparam int END_CYCLES         = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit                    gaps_on;
  int                    hold_reqs;
  int                    holds_done;
  int                    mismatches;
  int                    pending;
  int                    results_seen;
  int                    bytes_sent;
  int                    images_sent;
  int                    settings_used;
  logic [HDR_W-1:0]      cur_skip;
  logic [MAGIC_W-1:0]    cur_magic;

  lsd_in_if  in_ch ();
  lsd_out_if out_ch ();

  lsb_stego_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lsd_result_checker result_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_done++;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(99) < 18);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic f);
    while (gaps_on && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cover_byte <= b;
    in_ch.first <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic int payload_bytes(logic [31:0] size, logic [31:0] ext);
    int n;
    n = 0;
    if (!ext[31] && ext <= MAX_EXT_LEN) n = int'(ext);
    if (!size[31]) n += (size > 6) ? 6 : int'(size);
    return n;
  endfunction

  // Hidden fields go MSB first into the LSBs of the bytes that follow the header.
  task automatic send_image(input logic [15:0] magic, input logic [31:0] size,
                            input logic [31:0] ext, input int keep_bits, input int tail);
    bit         hidden[$];
    logic [7:0] raw;
    int         k;
    for (k = 15; k >= 0; k--) hidden.push_back(magic[k]);
    for (k = 31; k >= 0; k--) hidden.push_back(size[k]);
    for (k = 31; k >= 0; k--) hidden.push_back(ext[k]);
    for (k = 0; k < 8 * payload_bytes(size, ext); k++) hidden.push_back($urandom_range(1));
    if (keep_bits > 0) while (hidden.size() > keep_bits) void'(hidden.pop_back());
    for (k = 0; k < cur_skip; k++) send_byte(8'($urandom), k == 0);
    for (k = 0; k < hidden.size(); k++) begin
      raw = 8'($urandom);
      raw[0] = hidden[k];
      send_byte(raw, cur_skip == 0 && k == 0);
    end
    bytes_sent += int'(cur_skip) + hidden.size();
    for (k = 0; k < tail; k++) send_byte(8'($urandom), 1'b0);
    images_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [HDR_W-1:0] skip, input logic [MAGIC_W-1:0] magic);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_HEADER_SKIP;
    cfg_data <= CFG_DATA_W'(skip);
    @(posedge clk);
    cfg_index <= CFG_MAGIC_WORD;
    cfg_data <= CFG_DATA_W'(magic);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_skip = skip;
    cur_magic = magic;
    settings_used++;
  endtask

  initial begin : stimulus
    int                 rand_images;
    int                 pick;
    int                 keep;
    int                 byte_base;
    logic [31:0]        size;
    logic [31:0]        ext;
    logic [MAGIC_W-1:0] magic;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_HEADER_SKIP;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cover_byte <= '0;
    in_ch.first <= 1'b0;
    gaps_on <= 1'b1;
    hold_reqs <= 0;
    cur_skip = HEADER_SKIP_RESET;
    cur_magic = MAGIC_WORD_RESET;
    settings_used = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_image(cur_magic, 32'd3, 32'd2, -1, 0);

    set_config('0, 16'h0000);
    gaps_on <= 1'b0;
    send_image(16'h0100, 32'd0, 32'd0, -1, 0);
    send_image(16'h0001, 32'd0, 32'd0, -1, 0);
    send_image(16'h0000, 32'd0, 32'd0, -1, 2);
    send_image(16'h0000, 32'h8000_0000, 32'd0, -1, 0);
    send_image(16'h0000, 32'd0, MAX_EXT_LEN, -1, 0);
    send_image(16'h0000, 32'd2, MAX_EXT_LEN + 1, -1, 0);
    send_image(16'h0000, 32'd2, 32'h7FFF_FFFF, -1, 0);
    send_image(16'h0000, 32'd2, 32'hFFFF_FFFF, -1, 0);
    send_image(16'h0000, 32'h7FFF_FFFF, 32'd1, -1, 0);
    send_image(16'h0000, 32'd5, 32'd2, 40, 0);
    send_image(16'h0000, 32'd1, 32'd0, -1, 0);
    gaps_on <= 1'b1;

    set_config(10'd96, 16'hFFFF);
    send_image(16'hFFFF, 32'd1, 32'd1, -1, 0);

    rand_images = 0;
    byte_base = bytes_sent;
    while (bytes_sent - byte_base < RANDOM_BYTES) begin
      if (rand_images % 6 == 0) begin
        pick = $urandom_range(9);
        set_config(pick == 0 ? 10'($urandom_range(60, 7)) : 10'($urandom_range(6)),
                   pick == 1 ? 16'h0000 : pick == 2 ? 16'hFFFF : 16'($urandom));
      end
      case ($urandom_range(9))
        0: size = 32'd0;
        1: size = 32'h8000_0000 | 32'($urandom);
        2: size = 32'h7FFF_FFFF;
        3: size = 32'($urandom);
        default: size = 32'($urandom_range(6, 1));
      endcase
      ext = 32'($urandom_range(MAX_EXT_LEN));
      magic = cur_magic;
      keep = -1;
      pick = $urandom_range(99);
      if (rand_images == 0) begin
        hold_reqs <= hold_reqs + 1;
        size = 32'd6;
        ext = 32'd3;
      end else if (pick < 60) begin
      end else if (pick < 75) begin
        magic = magic ^ (16'd1 << $urandom_range(15));
      end else if (pick < 85) begin
        ext = $urandom_range(1) ? 32'($urandom_range(40, MAX_EXT_LEN + 1))
                                : {1'b0, 31'($urandom)};
      end else if (pick < 95) begin
        keep = $urandom_range(80 + 8 * payload_bytes(size, ext), 1);
      end else begin
        ext = 32'h8000_0000 | 32'($urandom);
      end
      send_image(magic, size, ext, keep, $urandom_range(3));
      rand_images++;
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    $display("Covered %0d images, %0d parsed image bytes, %0d register settings.",
             images_sent, bytes_sent, settings_used);
    $display("Checked %0d decoded results, including a %0d-cycle result-side hold.",
             results_seen, HOLD_CYCLES);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* lsb_stego_stream_decoder.f */
src/lsd_pkg.sv
src/lsd_if.sv
src/lsb_stego_stream_decoder.sv
dv/lsd_result_checker.sv
dv/lsb_stego_stream_decoder_test.sv
